// ===== src/auth_prefix_hash_matcher_core_assert.svh =====
// Assertion macros for the authentication prefix matcher checker.
// Included by the checker file; needs nothing else.
`ifndef AUTH_PREFIX_HASH_MATCHER_CORE_ASSERT_SVH
`define AUTH_PREFIX_HASH_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define APHM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aphm check failed");

// Next-cycle implication, disabled while reset is high.
`define APHM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aphm check failed");

// Next-cycle implication that stays active through reset.
`define APHM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("aphm check failed");

`endif

// ===== src/aphm_pkg.sv =====
// Shared types and codes of the authentication prefix matcher.
// Used by the scan unit, the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package aphm_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_DATA = 2'd0;
   localparam logic [1:0] FUNC_LOAD = 2'd1;
   localparam logic [1:0] FUNC_NEW  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_NEED     = 2'd0;
   localparam logic [1:0] STATUS_AUTH     = 2'd1;
   localparam logic [1:0] STATUS_FALLBACK = 2'd2;
   localparam logic [1:0] STATUS_ACK      = 2'd3;

   // User counts go up to 127, so nine bits hold any clamped count.
   localparam int USER_CNT_W = 9;

   // Per-connection phase.
   typedef enum logic [3:0] {
      PH_COLLECT  = 4'b0001,
      PH_PADDING  = 4'b0010,
      PH_FALLBACK = 4'b0100,
      PH_AUTH     = 4'b1000
   } phase_type;

   // Control sequencer of the top level.
   typedef enum logic [1:0] {
      CS_IDLE = 2'b01,
      CS_SCAN = 2'b10
   } ctl_state_type;

   // Start of a table scan.
   typedef struct packed {
      logic                  start;
      logic [USER_CNT_W-1:0] count;
   } scan_ctl_type;

   // Outcome of a table scan.
   typedef struct packed {
      logic       done;
      logic       found;
      logic [5:0] user;
   } scan_res_type;

endpackage

`default_nettype wire

// ===== src/aphm_chan_if.sv =====
// Handshake channel interfaces of the authentication prefix matcher.
// Standalone; the top level and its environment use them.
`default_nettype none

// Request channel: stream bytes, table loads and connection restarts.
interface aphm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  data_byte;
   logic [5:0]  user_slot;
   logic [1:0]  word_slot;
   logic [63:0] hash_word;

   modport source (output valid, func, data_byte, user_slot, word_slot, hash_word,
                   input ready);
   modport sink   (input valid, func, data_byte, user_slot, word_slot, hash_word,
                   output ready);
endinterface

// Response channel: one response per request.
interface aphm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        consumed;
   logic [5:0]  matched_user;
   logic [15:0] padding_length;

   modport source (output valid, status, consumed, matched_user, padding_length,
                   input ready);
   modport sink   (input valid, status, consumed, matched_user, padding_length,
                   output ready);
endinterface

// Register write channel for the user count.
interface aphm_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] user_count;

   modport source (output valid, user_count, input ready);
   modport sink   (input valid, user_count, output ready);
endinterface

`default_nettype wire

// ===== src/aphm_user_ram.sv =====
// User hash table: one write port, one registered read port.
// Standalone storage; the top level writes it and the scan unit reads it.
`default_nettype none

module aphm_user_ram #(
   parameter int DEPTH,
   parameter int ADDR_W
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [63:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [63:0]       rd_data
);

   logic [63:0] mem_ff [DEPTH];
   logic [63:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/aphm_scan.sv =====
// Table scan unit: walks the user hash table word by word and finds the
// first user whose hash equals the received hash. Uses aphm_pkg.
`default_nettype none

module aphm_scan #(
   parameter int MAX_USERS,
   parameter int HASH_BYTES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire aphm_pkg::scan_ctl_type              ctl,
   input  wire logic [((HASH_BYTES+7)/8)*64-1:0]    hash_vec,
   output logic                                     ram_rd_en,
   output logic [((MAX_USERS*((HASH_BYTES+7)/8)) > 1 ?
                  $clog2(MAX_USERS*((HASH_BYTES+7)/8)) : 1)-1:0] ram_rd_addr,
   input  wire logic [63:0]                         ram_rd_data,
   output aphm_pkg::scan_res_type                   res
);

   localparam int HASH_WORDS = (HASH_BYTES + 7) / 8;
   localparam int DEPTH      = MAX_USERS * HASH_WORDS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int W_W        = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
   localparam int UIDX_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int CNT_W      = aphm_pkg::USER_CNT_W;
   localparam int REM_BYTES  = HASH_BYTES % 8;
   localparam logic [63:0] LAST_MASK =
      (REM_BYTES == 0) ? {64{1'b1}} : ({64{1'b1}} << ((8 - REM_BYTES) * 8));
   localparam logic [W_W-1:0] LAST_WORD = W_W'(HASH_WORDS - 1);

   // Issue stage.
   logic              run_ff;
   logic              iss_done_ff;
   logic [UIDX_W-1:0] iss_u_ff;
   logic [W_W-1:0]    iss_w_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]  n_ff;
   // Compare stage.
   logic              rd_vld_ff;
   logic [W_W-1:0]    rd_w_ff;
   logic [UIDX_W-1:0] rd_u_ff;
   logic              rd_last_ff;
   logic              rd_final_ff;
   logic              mism_ff;

   logic              issue;
   logic              iss_last_w;
   logic              iss_last_u;
   logic [63:0]       sel_word;
   logic [63:0]       word_mask;
   logic              word_diff;
   logic              mis;
   logic              hit;
   logic              miss_all;

   assign issue      = run_ff && !iss_done_ff;
   assign iss_last_w = (iss_w_ff == LAST_WORD);
   assign iss_last_u = (CNT_W'(iss_u_ff) == (n_ff - CNT_W'(1)));

   assign ram_rd_en   = issue;
   assign ram_rd_addr = addr_ff;

   // Compare the word read last cycle against the matching received word.
   assign sel_word  = hash_vec[64 * (HASH_WORDS - 1 - int'(rd_w_ff)) +: 64];
   assign word_mask = (rd_w_ff == LAST_WORD) ? LAST_MASK : {64{1'b1}};
   assign word_diff = |((ram_rd_data ^ sel_word) & word_mask);
   assign mis       = mism_ff || word_diff;
   assign hit       = run_ff && rd_vld_ff && rd_last_ff && !mis;
   assign miss_all  = run_ff && rd_vld_ff && rd_final_ff && mis;

   assign res.done  = hit || miss_all;
   assign res.found = hit;
   assign res.user  = 6'(rd_u_ff);

   // Scan control: the run flag and the read-valid flag are the only state with a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else if (ctl.start) begin
         run_ff    <= 1'b1;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (res.done) begin
            run_ff <= 1'b0;
         end
      end
   end

   // Address sequencing and compare bookkeeping.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         iss_done_ff <= 1'b0;
         iss_u_ff    <= '0;
         iss_w_ff    <= '0;
         addr_ff     <= '0;
         n_ff        <= ctl.count;
         mism_ff     <= 1'b0;
      end else begin
         if (issue) begin
            addr_ff <= addr_ff + ADDR_W'(1);
            if (iss_last_w) begin
               iss_w_ff <= '0;
               iss_u_ff <= iss_u_ff + UIDX_W'(1);
               if (iss_last_u) begin
                  iss_done_ff <= 1'b1;
               end
            end else begin
               iss_w_ff <= iss_w_ff + W_W'(1);
            end
         end
         if (run_ff && rd_vld_ff) begin
            mism_ff <= rd_last_ff ? 1'b0 : mis;
         end
      end
      rd_w_ff     <= iss_w_ff;
      rd_u_ff     <= iss_u_ff;
      rd_last_ff  <= iss_last_w;
      rd_final_ff <= iss_last_w && iss_last_u;
   end

endmodule

`default_nettype wire

// ===== src/auth_prefix_hash_matcher_core.sv =====
// Response: registered after each request, except for the last prefix byte, whose
// response waits for a table scan that stops at the first matching user (or after
// the last user scanned, one below the clamped user count, when none matches);
// with a user count of zero it falls back without a scan.
// Throughput: one request per cycle while no scan runs and the response side is ready.
// Reset: synchronous; clears connection state and user count, table is not cleared.
`default_nettype none

module auth_prefix_hash_matcher_core #(
   parameter int MAX_USERS  = 64,
   parameter int HASH_BYTES = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   aphm_req_if.sink  req_ch,
   aphm_rsp_if.source rsp_ch,
   aphm_csr_if.sink  csr_ch
);

   localparam int HASH_WORDS = (HASH_BYTES + 7) / 8;
   localparam int BYTES_PAD  = HASH_WORDS * 8;
   localparam int BIDX_W     = $clog2(BYTES_PAD);
   localparam int DEPTH      = MAX_USERS * HASH_WORDS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = aphm_pkg::USER_CNT_W;
   localparam logic [16:0] HASH_CNT   = 17'(HASH_BYTES);
   localparam logic [16:0] PREFIX_CNT = 17'(HASH_BYTES + 2);
   localparam logic [16:0] BUFFER_CNT = 17'(HASH_BYTES + 2 + 65535);

   logic [6:0]                      user_count_ff;
   aphm_pkg::phase_type             phase_ff, phase_in;
   aphm_pkg::ctl_state_type         fsm_ff, fsm_in;
   logic [16:0]                     byte_count_ff, byte_count_in;
   logic [15:0]                     pad_len_ff, pad_len_in;
   logic [5:0]                      match_idx_ff, match_idx_in;
   logic [BYTES_PAD-1:0][7:0]       rh_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic                            rsp_consumed_ff, rsp_consumed_in;

   logic                            req_accept;
   logic [16:0]                     byte_count_inc;
   logic [CNT_W-1:0]                users;
   logic                            slot_ok;
   logic                            hash_we;
   logic                            ram_we;
   logic [ADDR_W-1:0]               ram_waddr;
   logic                            ram_re;
   logic [ADDR_W-1:0]               ram_raddr;
   logic [63:0]                     ram_rdata;
   aphm_pkg::scan_ctl_type          scan_ctl;
   aphm_pkg::scan_res_type          scan_res;

   // Handshakes: one request in flight, response register decouples the sink.
   assign req_ch.ready = (fsm_ff == aphm_pkg::CS_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.consumed       = rsp_consumed_ff;
   assign rsp_ch.matched_user   = match_idx_ff;
   assign rsp_ch.padding_length = pad_len_ff;

   // Clamp the user count to the table size.
   assign users = (int'(user_count_ff) > MAX_USERS) ? CNT_W'(MAX_USERS)
                                                     : CNT_W'(user_count_ff);

   // Table load address; out-of-range slots are dropped.
   assign slot_ok   = (int'(req_ch.user_slot) < MAX_USERS) &&
                      (int'(req_ch.word_slot) < HASH_WORDS);
   assign ram_waddr = ADDR_W'(int'(req_ch.user_slot) * HASH_WORDS + int'(req_ch.word_slot));

   assign byte_count_inc = byte_count_ff + 17'd1;

   // Per-request state update and response selection.
   always_comb begin
      phase_in        = phase_ff;
      fsm_in          = fsm_ff;
      byte_count_in   = byte_count_ff;
      pad_len_in      = pad_len_ff;
      match_idx_in    = match_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_consumed_in = rsp_consumed_ff;
      hash_we         = 1'b0;
      ram_we          = 1'b0;
      scan_ctl.start  = 1'b0;
      scan_ctl.count  = users;
      if (req_accept) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = aphm_pkg::STATUS_ACK;
         rsp_consumed_in = 1'b0;
         case (req_ch.func)
            aphm_pkg::FUNC_LOAD: begin
               ram_we = slot_ok;
            end
            aphm_pkg::FUNC_NEW: begin
               phase_in      = aphm_pkg::PH_COLLECT;
               byte_count_in = '0;
               pad_len_in    = '0;
               match_idx_in  = '0;
            end
            aphm_pkg::FUNC_DATA: begin
               case (phase_ff)
                  aphm_pkg::PH_COLLECT: begin
                     rsp_consumed_in = 1'b1;
                     rsp_status_in   = aphm_pkg::STATUS_NEED;
                     byte_count_in   = byte_count_inc;
                     if (byte_count_ff < HASH_CNT) begin
                        hash_we = 1'b1;
                     end else begin
                        pad_len_in = {pad_len_ff[7:0], req_ch.data_byte};
                     end
                     // The last prefix byte either falls back at once or starts a scan.
                     if (byte_count_inc >= PREFIX_CNT) begin
                        if (users == '0) begin
                           phase_in      = aphm_pkg::PH_FALLBACK;
                           rsp_status_in = aphm_pkg::STATUS_FALLBACK;
                        end else begin
                           scan_ctl.start = 1'b1;
                           rsp_valid_in   = 1'b0;
                           fsm_in         = aphm_pkg::CS_SCAN;
                        end
                     end
                  end
                  aphm_pkg::PH_PADDING: begin
                     rsp_consumed_in = 1'b1;
                     byte_count_in   = byte_count_inc;
                     if (byte_count_inc >= PREFIX_CNT + {1'b0, pad_len_ff}) begin
                        phase_in      = aphm_pkg::PH_AUTH;
                        rsp_status_in = aphm_pkg::STATUS_AUTH;
                     end else begin
                        rsp_status_in = aphm_pkg::STATUS_NEED;
                     end
                  end
                  aphm_pkg::PH_FALLBACK: begin
                     rsp_status_in = aphm_pkg::STATUS_FALLBACK;
                     if (byte_count_ff < BUFFER_CNT) begin
                        rsp_consumed_in = 1'b1;
                        byte_count_in   = byte_count_inc;
                     end
                  end
                  default: begin
                     rsp_status_in = aphm_pkg::STATUS_AUTH;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end else if ((fsm_ff == aphm_pkg::CS_SCAN) && scan_res.done) begin
         // Scan finished: respond to the last prefix byte.
         fsm_in          = aphm_pkg::CS_IDLE;
         rsp_valid_in    = 1'b1;
         rsp_consumed_in = 1'b1;
         if (scan_res.found) begin
            match_idx_in = scan_res.user;
            if (pad_len_ff == '0) begin
               phase_in      = aphm_pkg::PH_AUTH;
               rsp_status_in = aphm_pkg::STATUS_AUTH;
            end else begin
               phase_in      = aphm_pkg::PH_PADDING;
               rsp_status_in = aphm_pkg::STATUS_NEED;
            end
         end else begin
            phase_in      = aphm_pkg::PH_FALLBACK;
            rsp_status_in = aphm_pkg::STATUS_FALLBACK;
         end
      end
   end

   // Control and connection state.
   always_ff @(posedge clock) begin
      if (reset) begin
         user_count_ff <= '0;
         phase_ff      <= aphm_pkg::PH_COLLECT;
         fsm_ff        <= aphm_pkg::CS_IDLE;
         byte_count_ff <= '0;
         pad_len_ff    <= '0;
         match_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            user_count_ff <= csr_ch.user_count;
         end
         phase_ff      <= phase_in;
         fsm_ff        <= fsm_in;
         byte_count_ff <= byte_count_in;
         pad_len_ff    <= pad_len_in;
         match_idx_ff  <= match_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload and received hash bytes, first byte at the top.
   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_consumed_ff <= rsp_consumed_in;
      if (hash_we) begin
         rh_ff[BIDX_W'(BYTES_PAD - 1) - byte_count_ff[BIDX_W-1:0]] <= req_ch.data_byte;
      end
   end

   aphm_user_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.hash_word),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   aphm_scan #(
      .MAX_USERS  (MAX_USERS),
      .HASH_BYTES (HASH_BYTES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .hash_vec    (rh_ff),
      .ram_rd_en   (ram_re),
      .ram_rd_addr (ram_raddr),
      .ram_rd_data (ram_rdata),
      .res         (scan_res)
   );

endmodule

`default_nettype wire

// ===== src/aphm_checker.sv =====
// Port-level checks of the authentication prefix matcher and their binding.
// Uses aphm_pkg and the assertion macro header.
`default_nettype none

`include "auth_prefix_hash_matcher_core_assert.svh"

module aphm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_func,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_consumed,
   input wire logic [5:0]  rsp_matched_user,
   input wire logic [15:0] rsp_padding_length
);

   // No response is pending right after reset.
   `APHM_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // A stalled response keeps its fields.
   `APHM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_consumed) && $stable(rsp_matched_user) && $stable(rsp_padding_length))

   // Loads, restarts and unused codes are acknowledged on the next cycle.
   `APHM_ASSERT_NEXT(a_ack_next, clock, reset, req_valid && req_ready && (req_func != aphm_pkg::FUNC_DATA), rsp_valid && (rsp_status == aphm_pkg::STATUS_ACK) && !rsp_consumed)

   // A consumed byte never carries an acknowledge status.
   `APHM_ASSERT_SAME(a_consumed_status, clock, reset, rsp_valid && rsp_consumed, rsp_status != aphm_pkg::STATUS_ACK)

   // No new request is taken while a response waits.
   `APHM_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule

bind auth_prefix_hash_matcher_core aphm_checker u_aphm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_func           (req_ch.func),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_consumed       (rsp_ch.consumed),
   .rsp_matched_user   (rsp_ch.matched_user),
   .rsp_padding_length (rsp_ch.padding_length)
);

`default_nettype wire

// ===== tb/aphm_response_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the authentication prefix matcher: predicts each response
// from the accepted requests and compares it field by field.
// Depends on aphm_pkg and the channel interfaces in aphm_chan_if.sv.

module aphm_response_checker
   import aphm_pkg::*;
#(
   parameter int MAX_USERS  = 64,
   parameter int HASH_BYTES = 32
) (
   input wire logic clock,
   input wire logic reset,
   aphm_req_if      req_ch,
   aphm_rsp_if      rsp_ch,
   aphm_csr_if      csr_ch,
   output int       mismatch_count,
   output int       open_count,
   output int       checked_count
);

   localparam int HASH_WORDS   = (HASH_BYTES + 7) / 8;
   localparam int PREFIX_BYTES = HASH_BYTES + 2;
   localparam int BUFFER_BYTES = PREFIX_BYTES + 65535;

   typedef struct packed {
      logic [1:0]  status;
      logic        consumed;
      logic [5:0]  user;
      logic [15:0] pad_len;
   } auth_rsp_t;

   // Shadow copy of the block's state.
   logic [63:0] user_hash [MAX_USERS][HASH_WORDS];
   logic [63:0] rx_hash [HASH_WORDS];
   int          byte_total;
   logic [15:0] pad_len;
   phase_type   conn_phase;
   logic [5:0]  match_user;
   logic [6:0]  user_limit;
   auth_rsp_t   due_responses[$];

   // Per-connection state goes back to the start of a prefix.
   task automatic clear_connection();
      foreach (rx_hash[w]) rx_hash[w] = '0;
      byte_total = 0;
      pad_len    = '0;
      conn_phase = PH_COLLECT;
      match_user = '0;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] response %0d: %s is %0h, should be %0h",
               $time, checked_count, what, got, want);
      mismatch_count++;
   endtask

   // Works out the response to one accepted request and queues it.
   task automatic step_prefix_parser();
      auth_rsp_t   r;
      int          n_live;
      int          valid_bytes;
      logic        found;
      logic [63:0] diff;
      logic [63:0] keep;
      r.status   = STATUS_ACK;
      r.consumed = 1'b0;
      case (req_ch.func)
         FUNC_LOAD: begin
            if (req_ch.user_slot < MAX_USERS && req_ch.word_slot < HASH_WORDS)
               user_hash[req_ch.user_slot][req_ch.word_slot] = req_ch.hash_word;
         end
         FUNC_NEW: begin
            clear_connection();
         end
         FUNC_DATA: begin
            case (conn_phase)
               PH_COLLECT: begin
                  r.consumed = 1'b1;
                  if (byte_total < HASH_BYTES)
                     rx_hash[byte_total / 8][(7 - byte_total % 8) * 8 +: 8] =
                        req_ch.data_byte;
                  else
                     pad_len = {pad_len[7:0], req_ch.data_byte};
                  byte_total++;
                  // Last prefix byte: scan the live users for the first match.
                  if (byte_total >= PREFIX_BYTES) begin
                     n_live = (user_limit > MAX_USERS) ? MAX_USERS : int'(user_limit);
                     found  = 1'b0;
                     for (int u = 0; u < n_live && !found; u++) begin
                        diff = '0;
                        for (int w = 0; w < HASH_WORDS; w++) begin
                           valid_bytes = HASH_BYTES - 8 * w;
                           keep = (valid_bytes >= 8) ? ~64'd0 :
                                  (~64'd0 << ((8 - valid_bytes) * 8));
                           diff |= (rx_hash[w] ^ user_hash[u][w]) & keep;
                        end
                        if (diff == '0) begin
                           match_user = 6'(u);
                           found      = 1'b1;
                        end
                     end
                     if (!found)
                        conn_phase = PH_FALLBACK;
                     else if (pad_len == '0)
                        conn_phase = PH_AUTH;
                     else
                        conn_phase = PH_PADDING;
                  end
                  r.status = (conn_phase == PH_AUTH) ? STATUS_AUTH :
                             (conn_phase == PH_FALLBACK) ? STATUS_FALLBACK : STATUS_NEED;
               end
               PH_PADDING: begin
                  r.consumed = 1'b1;
                  byte_total++;
                  if (byte_total >= PREFIX_BYTES + int'(pad_len)) begin
                     conn_phase = PH_AUTH;
                     r.status   = STATUS_AUTH;
                  end else begin
                     r.status = STATUS_NEED;
                  end
               end
               PH_FALLBACK: begin
                  // Bytes are kept for replay only up to the buffer size.
                  r.status = STATUS_FALLBACK;
                  if (byte_total < BUFFER_BYTES) begin
                     r.consumed = 1'b1;
                     byte_total++;
                  end
               end
               default: begin
                  r.status = STATUS_AUTH;
               end
            endcase
         end
         default: begin
            // The unused function code only gets an acknowledge.
         end
      endcase
      r.user    = match_user;
      r.pad_len = pad_len;
      due_responses.push_back(r);
   endtask

   // Compares one accepted response with the oldest prediction.
   task automatic check_response();
      auth_rsp_t want;
      if (due_responses.size() == 0) begin
         report_mismatch("response without a pending request, status",
                         16'(rsp_ch.status), 16'(STATUS_ACK));
         return;
      end
      want = due_responses.pop_front();
      if (rsp_ch.status !== want.status)
         report_mismatch("status", 16'(rsp_ch.status), 16'(want.status));
      if (rsp_ch.consumed !== want.consumed)
         report_mismatch("consumed", 16'(rsp_ch.consumed), 16'(want.consumed));
      if (rsp_ch.matched_user !== want.user)
         report_mismatch("matched_user", 16'(rsp_ch.matched_user), 16'(want.user));
      if (rsp_ch.padding_length !== want.pad_len)
         report_mismatch("padding_length", rsp_ch.padding_length, want.pad_len);
      checked_count++;
   endtask

   // Responses are checked before the requests of the same edge are predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_connection();
         user_limit = '0;
         due_responses.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_response();
         if (csr_ch.valid && csr_ch.ready)
            user_limit = csr_ch.user_count;
         if (req_ch.valid && req_ch.ready)
            step_prefix_parser();
      end
      open_count = due_responses.size();
   end

endmodule

// ===== tb/tb_auth_prefix_hash_matcher_core.sv =====
`timescale 1ns / 100ps
// Testbench top for auth_prefix_hash_matcher_core: drives requests, the user count
// register and response back-pressure, and gives the verdict.
// Depends on aphm_pkg, aphm_chan_if.sv, the block and aphm_response_checker.

module tb_auth_prefix_hash_matcher_core;
   import aphm_pkg::*;

   localparam int MAX_USERS    = 64;
   localparam int HASH_BYTES   = 32;
   localparam int HASH_WORDS   = (HASH_BYTES + 7) / 8;
   localparam int PREFIX_BYTES = HASH_BYTES + 2;
   localparam int IDLE_MAX     = 17;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 75;
   localparam int NUM_PHASES   = 7;

   // Function code that the block does not use.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {
      CONN_BARE_MATCH,
      CONN_PADDED_MATCH,
      CONN_STRANGER,
      CONN_NEAR_MISS,
      CONN_CUT_PADDING,
      CONN_CUT_PREFIX
   } conn_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aphm_req_if req_ch ();
   aphm_rsp_if rsp_ch ();
   aphm_csr_if csr_ch ();

   int mismatch_count;
   int open_count;
   int checked_count;

   // Stimulus-side copy of the user table, used to build matching prefixes.
   logic [63:0] user_tab [MAX_USERS][HASH_WORDS];
   int          user_count_now = 0;
   bit          idle_en = 1'b1;
   int          holds_asked = 0;
   int          holds_done = 0;
   int          items_sent = 0;
   int          conn_total = 0;
   int          cfg_writes = 0;
   int          quiet_cycles = 0;

   auth_prefix_hash_matcher_core #(
      .MAX_USERS (MAX_USERS),
      .HASH_BYTES(HASH_BYTES)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   aphm_response_checker #(
      .MAX_USERS (MAX_USERS),
      .HASH_BYTES(HASH_BYTES)
   ) rsp_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .mismatch_count(mismatch_count),
      .open_count    (open_count),
      .checked_count (checked_count)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Offers one request after a random gap and waits for it to be taken.
   task automatic send_request(input logic [1:0] func, input logic [7:0] data_byte,
                               input logic [5:0] uslot, input logic [1:0] wslot,
                               input logic [63:0] word);
      int gap;
      gap = idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.data_byte <= data_byte;
      req_ch.user_slot <= uslot;
      req_ch.word_slot <= wslot;
      req_ch.hash_word <= word;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Stream byte; the fields it does not use carry noise.
   task automatic send_byte(input logic [7:0] data_byte);
      send_request(FUNC_DATA, data_byte, 6'($urandom), 2'($urandom), rand_word());
   endtask

   task automatic load_user_word(input int user, input int word_idx,
                                 input logic [63:0] word);
      user_tab[user][word_idx] = word;
      send_request(FUNC_LOAD, 8'($urandom), 6'(user), 2'(word_idx), word);
   endtask

   // Waits until every response has come back, then lets the block settle.
   task automatic drain(input int tail);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_user_count(input logic [6:0] value);
      csr_ch.valid      <= 1'b1;
      csr_ch.user_count <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      user_count_now = int'(value);
      cfg_writes++;
   endtask

   // One connection: restart, prefix bytes, then padding or trailing bytes.
   task automatic send_connection(input conn_kind_type kind);
      logic [7:0] prefix [PREFIX_BYTES];
      int         n_eff;
      int         user;
      int         pos;
      int         pad;
      int         n_prefix;
      int         n_after;
      n_eff = (user_count_now > MAX_USERS) ? MAX_USERS : user_count_now;
      user  = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : $urandom_range(0, MAX_USERS - 1);
      for (int i = 0; i < HASH_BYTES; i++)
         prefix[i] = (kind == CONN_STRANGER) ? 8'($urandom) :
                     user_tab[user][i / 8][(7 - i % 8) * 8 +: 8];
      // A near miss differs from a user hash in exactly one byte.
      if (kind == CONN_NEAR_MISS) begin
         pos = $urandom_range(0, HASH_BYTES - 1);
         prefix[pos] = prefix[pos] ^ 8'($urandom_range(1, 255));
      end
      case (kind)
         CONN_BARE_MATCH: begin
            prefix[HASH_BYTES]     = 8'd0;
            prefix[HASH_BYTES + 1] = 8'd0;
         end
         CONN_PADDED_MATCH: begin
            prefix[HASH_BYTES]     = 8'd0;
            prefix[HASH_BYTES + 1] = 8'($urandom_range(1, 6));
         end
         CONN_NEAR_MISS: begin
            prefix[HASH_BYTES]     = 8'd0;
            prefix[HASH_BYTES + 1] = 8'($urandom_range(0, 3));
         end
         default: begin
            prefix[HASH_BYTES]     = 8'($urandom);
            prefix[HASH_BYTES + 1] = 8'($urandom);
         end
      endcase
      pad = int'({prefix[HASH_BYTES], prefix[HASH_BYTES + 1]});
      n_prefix = (kind == CONN_CUT_PREFIX) ? $urandom_range(1, PREFIX_BYTES - 1) :
                 PREFIX_BYTES;
      case (kind)
         CONN_BARE_MATCH:   n_after = $urandom_range(1, 3);
         CONN_PADDED_MATCH: n_after = pad + $urandom_range(0, 2);
         CONN_NEAR_MISS:    n_after = pad + $urandom_range(0, 3);
         CONN_STRANGER:     n_after = $urandom_range(0, 5);
         CONN_CUT_PADDING:  n_after = $urandom_range(1, 8);
         default:           n_after = 0;
      endcase
      send_request(FUNC_NEW, 8'($urandom), 6'($urandom), 2'($urandom), rand_word());
      for (int i = 0; i < n_prefix; i++)
         send_byte(prefix[i]);
      for (int i = 0; i < n_after; i++)
         send_byte(8'($urandom));
      conn_total++;
   endtask

   // Response side: a random stall before each response, or a long hold on request.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < holds_asked) begin
            gap = HOLD_CYCLES;
            holds_done++;
         end else begin
            gap = idle_en ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Ends the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d responses still due",
                  quiet_cycles, open_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Main stimulus sequence.
   initial begin
      int            phase_start;
      int            pick;
      conn_kind_type kind;
      logic [6:0]    cfg;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_DATA;
      req_ch.data_byte  <= '0;
      req_ch.user_slot  <= '0;
      req_ch.word_slot  <= '0;
      req_ch.hash_word  <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.user_count <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table so no scan ever reads an unwritten entry.
      // Users 10 and 40 repeat user 3, so the first match has to win.
      for (int u = 0; u < MAX_USERS; u++)
         for (int w = 0; w < HASH_WORDS; w++)
            load_user_word(u, w, (u == 10 || u == 40) ? user_tab[3][w] :
                                 (u == 0 && w == 0) ? 64'h00FF_5AA5_C33C_FF00 :
                                 rand_word());

      // Short directed part: unused code, stray bytes and extreme fields.
      send_request(FUNC_UNUSED, 8'hFF, 6'h3F, 2'h3, ~64'd0);
      send_byte(8'hFF);
      send_request(FUNC_DATA, 8'h00, 6'h3F, 2'h3, ~64'd0);
      send_request(FUNC_NEW, 8'h00, 6'h00, 2'h0, 64'd0);
      send_request(FUNC_NEW, 8'hFF, 6'h3F, 2'h3, ~64'd0);
      load_user_word(MAX_USERS - 1, HASH_WORDS - 1, ~64'd0);
      load_user_word(MAX_USERS - 2, 0, 64'd0);
      send_request(FUNC_UNUSED, 8'h00, 6'h00, 2'h0, 64'd0);

      // Random connections under several user counts, extremes included.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain(4);
         case (p)
            0:       cfg = 7'd64;
            1:       cfg = 7'd1;
            2:       cfg = 7'd127;
            3:       cfg = 7'd0;
            4:       cfg = 7'($urandom_range(2, 63));
            5:       cfg = 7'($urandom_range(65, 126));
            default: cfg = 7'd64;
         endcase
         write_user_count(cfg);
         if (p == 2)
            holds_asked++;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // The first connections walk through every kind once.
            if (conn_total < 6) begin
               kind = conn_kind_type'(conn_total);
            end else begin
               pick = $urandom_range(0, 9);
               kind = (pick < 2) ? CONN_BARE_MATCH :
                      (pick < 5) ? CONN_PADDED_MATCH :
                      (pick < 7) ? CONN_STRANGER :
                      (pick < 8) ? CONN_NEAR_MISS :
                      (pick < 9) ? CONN_CUT_PADDING : CONN_CUT_PREFIX;
            end
            idle_en = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 2))
                  0:       load_user_word($urandom_range(0, MAX_USERS - 1),
                                          $urandom_range(0, HASH_WORDS - 1), rand_word());
                  1:       send_request(FUNC_UNUSED, 8'($urandom), 6'($urandom),
                                        2'($urandom), rand_word());
                  default: send_byte(8'($urandom));
               endcase
            end
            send_connection(kind);
         end
      end
      idle_en = 1'b1;

      drain(TAIL_CYCLES);
      $display("Covered %0d requests in %0d connections under %0d user count settings,",
               items_sent, conn_total, cfg_writes);
      $display("with duplicate user hashes, cut-short connections and a long response hold.");
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/aphm_pkg.sv
src/aphm_chan_if.sv
src/aphm_user_ram.sv
src/aphm_scan.sv
src/auth_prefix_hash_matcher_core.sv
src/aphm_checker.sv
tb/aphm_response_checker.sv
tb/tb_auth_prefix_hash_matcher_core.sv
